/* design/pulse_sum_peak_and_window_integral_macros.svh */
// Assertion macros for the pulse sum, peak and window integral block.
// No dependencies; included by the RTL files that carry assertions.
`ifndef PULSE_SUM_PEAK_AND_WINDOW_INTEGRAL_MACROS_SVH
`define PULSE_SUM_PEAK_AND_WINDOW_INTEGRAL_MACROS_SVH
`ifndef SYNTHESIS
`define PSPWI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define PSPWI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`define PSPWI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define PSPWI_ASSERT(label, clk, rst, prop)
`define PSPWI_ASSERT_IMP(label, clk, rst, ante, cons)
`define PSPWI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/pspwi_pkg.sv */
// Package for the pulse sum, peak and window integral block.
// Field widths, saturation limits, the sequencer state type and the entry saturating add; no dependencies.
`default_nettype none
package pspwi_pkg;
   localparam int POS_W   = 12;
   localparam int AMP_W   = 16;
   localparam int WIDTH_W = 11;
   localparam int ENTRY_W = 24;
   localparam int SUM_W   = 34;

   localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 24'sh7FFFFF;
   localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 24'sh800000;
   localparam logic signed [SUM_W-1:0]   SUM_MAX   = 34'sh1FFFFFFFF;
   localparam logic signed [SUM_W-1:0]   SUM_MIN   = 34'sh200000000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_SCAN,
      ST_SUM,
      ST_DONE
   } state_type;

   // entry + sample, clamped to the entry range
   function automatic logic signed [ENTRY_W-1:0] sat_entry(
      input logic signed [ENTRY_W-1:0] cur,
      input logic signed [AMP_W-1:0]   amp
   );
      logic signed [ENTRY_W:0] s;
      s = (ENTRY_W+1)'(cur) + (ENTRY_W+1)'(amp);
      if (s > (ENTRY_W+1)'(ENTRY_MAX)) begin
         return ENTRY_MAX;
      end else if (s < (ENTRY_W+1)'(ENTRY_MIN)) begin
         return ENTRY_MIN;
      end else begin
         return s[ENTRY_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

/* design/pulse_sum_peak_and_window_integral.sv */
// Pulse sum, peak and window integral: top level, sum buffers and sequencer.
// Depends on pspwi_pkg and pulse_sum_peak_and_window_integral_macros.svh.
//
//   channel   ports                        handshake
//   input     req_position .. last_sample  start, accepted when !busy
//   result    rsp_peak_amplitude .. first  rsp_valid, one cycle, no stall
//   csr       csr_wr_data                  csr_wr_en, written at once
//
// A sample is a buffer read, then an add and write back.
// A last sample adds a scan for the peak, a sum pass from PRE_PEAK entries before the
// peak to the end of the window, a result pulse and a clear of all MAX_WINDOW entries.
// After reset busy stays high for the clearing pass over all MAX_WINDOW entries.
`default_nettype none
`include "pulse_sum_peak_and_window_integral_macros.svh"
module pulse_sum_peak_and_window_integral #(
   parameter int MAX_WINDOW = 1024,
   parameter int PRE_PEAK   = 10,
   parameter int PROMPT_LEN = 30
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       start,
   output logic                                            busy,
   input  wire logic signed [pspwi_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [pspwi_pkg::AMP_W-1:0]         req_amplitude,
   input  wire logic                                       req_second_pass,
   input  wire logic                                       req_last_sample,
   input  wire logic                                       csr_wr_en,
   input  wire logic [pspwi_pkg::WIDTH_W-1:0]              csr_wr_data,
   output logic                                            rsp_valid,
   output logic signed [pspwi_pkg::ENTRY_W-1:0]            rsp_peak_amplitude,
   output logic [$clog2(MAX_WINDOW)-1:0]                   rsp_peak_offset,
   output logic signed [pspwi_pkg::SUM_W-1:0]              rsp_total_both,
   output logic signed [pspwi_pkg::SUM_W-1:0]              rsp_prompt_both,
   output logic signed [pspwi_pkg::SUM_W-1:0]              rsp_total_first,
   output logic signed [pspwi_pkg::SUM_W-1:0]              rsp_prompt_first
);
   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W  = (CNT_W > pspwi_pkg::WIDTH_W) ? CNT_W : pspwi_pkg::WIDTH_W;
   localparam int ACC_W  = pspwi_pkg::ENTRY_W + CNT_W + 2;
   localparam int PRM_W  = $clog2(PROMPT_LEN + 1);
   localparam int PK_W   = ADDR_W + 2;
   localparam int EW     = pspwi_pkg::ENTRY_W;

   localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_WINDOW);
   localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(MAX_WINDOW - 1);
   localparam logic [PK_W-1:0]  PRE_K     = PK_W'(PRE_PEAK);
   localparam logic [PRM_W-1:0] PRM_K     = PRM_W'(PROMPT_LEN);

   pspwi_pkg::state_type state_ff, state_in;

   logic [pspwi_pkg::WIDTH_W-1:0] window_width_ff;
   logic [CMP_W-1:0]              width_cmp, w_eff_cmp, pos_cmp;
   logic [CNT_W-1:0]              w_eff;

   logic                          win_ff;
   logic signed [pspwi_pkg::AMP_W-1:0] amp_ff;
   logic                          pass2_ff, last_ff;
   logic [ADDR_W-1:0]             addr_ff;

   logic [CNT_W-1:0]              idx_ff;
   logic                          rdv_ff, prompt_d_ff;
   logic [ADDR_W-1:0]             rd_idx_ff;
   logic [PRM_W-1:0]              prm_cnt_ff;

   logic signed [EW-1:0]          max_ff;
   logic [ADDR_W-1:0]             peak_ff;
   logic [PK_W-1:0]               peak_ext, start_diff;
   logic [CNT_W-1:0]              span_start;

   logic signed [ACC_W-1:0]       tot_b_ff, pr_b_ff, tot_f_ff, pr_f_ff;
   logic signed [ACC_W-1:0]       f_ext, b_ext;

   logic signed [EW-1:0]          mem_first  [MAX_WINDOW];
   logic signed [EW-1:0]          mem_second [MAX_WINDOW];
   logic signed [EW-1:0]          rd_first_ff, rd_second_ff;
   logic [ADDR_W-1:0]             rd_addr, wr_addr;
   logic signed [EW-1:0]          wr_data, acc_cur;
   logic                          we_first, we_second;

   logic                          accept, issue, scan_done, sum_done, clear_done;
   logic                          peak_ok, peak_floor_ok, clear_entry, acc_exit_ok;

   function automatic logic signed [pspwi_pkg::SUM_W-1:0] sat_sum(
      input logic signed [ACC_W-1:0] v
   );
      if (v > ACC_W'(pspwi_pkg::SUM_MAX)) begin
         return pspwi_pkg::SUM_MAX;
      end else if (v < ACC_W'(pspwi_pkg::SUM_MIN)) begin
         return pspwi_pkg::SUM_MIN;
      end else begin
         return v[pspwi_pkg::SUM_W-1:0];
      end
   endfunction

   // effective width and window check
   assign width_cmp = CMP_W'(window_width_ff);
   assign w_eff_cmp = (width_cmp > MAX_CMP) ? MAX_CMP : width_cmp;
   assign w_eff     = w_eff_cmp[CNT_W-1:0];
   assign pos_cmp   = CMP_W'(req_position[pspwi_pkg::POS_W-2:0]);

   assign accept     = start && (state_ff == pspwi_pkg::ST_IDLE);
   assign issue      = ((state_ff == pspwi_pkg::ST_SCAN) || (state_ff == pspwi_pkg::ST_SUM))
                       && (idx_ff < w_eff);
   assign scan_done  = (state_ff == pspwi_pkg::ST_SCAN) && !issue && !rdv_ff;
   assign sum_done   = (state_ff == pspwi_pkg::ST_SUM) && !issue && !rdv_ff;
   assign clear_done = (state_ff == pspwi_pkg::ST_CLEAR) && (idx_ff == LAST_IDX);

   assign peak_ext   = PK_W'(peak_ff);
   assign start_diff = peak_ext - PRE_K;
   assign span_start = (peak_ext >= PRE_K) ? CNT_W'(start_diff[ADDR_W-1:0]) : '0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pspwi_pkg::ST_CLEAR: begin
            if (clear_done) state_in = pspwi_pkg::ST_IDLE;
         end
         pspwi_pkg::ST_IDLE: begin
            if (start) state_in = pspwi_pkg::ST_ACC;
         end
         pspwi_pkg::ST_ACC: begin
            state_in = last_ff ? pspwi_pkg::ST_SCAN : pspwi_pkg::ST_IDLE;
         end
         pspwi_pkg::ST_SCAN: begin
            if (scan_done) state_in = pspwi_pkg::ST_SUM;
         end
         pspwi_pkg::ST_SUM: begin
            if (sum_done) state_in = pspwi_pkg::ST_DONE;
         end
         pspwi_pkg::ST_DONE: begin
            state_in = pspwi_pkg::ST_CLEAR;
         end
         default: begin
            state_in = pspwi_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs and memory port control
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      rd_addr   = idx_ff[ADDR_W-1:0];
      wr_addr   = addr_ff;
      wr_data   = '0;
      we_first  = 1'b0;
      we_second = 1'b0;
      acc_cur   = pass2_ff ? rd_second_ff : rd_first_ff;
      case (state_ff)
         pspwi_pkg::ST_CLEAR: begin
            wr_addr   = idx_ff[ADDR_W-1:0];
            we_first  = 1'b1;
            we_second = 1'b1;
         end
         pspwi_pkg::ST_IDLE: begin
            busy    = 1'b0;
            rd_addr = pos_cmp[ADDR_W-1:0];
         end
         pspwi_pkg::ST_ACC: begin
            wr_data   = pspwi_pkg::sat_entry(acc_cur, amp_ff);
            we_first  = win_ff && !pass2_ff;
            we_second = win_ff && pass2_ff;
         end
         pspwi_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_first) begin
         mem_first[wr_addr] <= wr_data;
      end
      rd_first_ff <= mem_first[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we_second) begin
         mem_second[wr_addr] <= wr_data;
      end
      rd_second_ff <= mem_second[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pspwi_pkg::ST_CLEAR;
         window_width_ff <= '0;
         idx_ff          <= '0;
         rdv_ff          <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= issue;
         if (csr_wr_en) begin
            window_width_ff <= csr_wr_data;
         end
         if (clear_done || (state_ff == pspwi_pkg::ST_ACC)
             || (state_ff == pspwi_pkg::ST_DONE)) begin
            idx_ff <= '0;
         end else if (scan_done) begin
            idx_ff <= span_start;
         end else if (issue || (state_ff == pspwi_pkg::ST_CLEAR)) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff   <= !req_position[pspwi_pkg::POS_W-1] && (pos_cmp < w_eff_cmp);
         addr_ff  <= pos_cmp[ADDR_W-1:0];
         amp_ff   <= req_amplitude;
         pass2_ff <= req_second_pass;
         last_ff  <= req_last_sample;
      end
   end

   // scan and integration
   assign f_ext = ACC_W'(rd_first_ff);
   assign b_ext = ACC_W'(rd_first_ff) + ACC_W'(rd_second_ff);

   always_ff @(posedge clock) begin
      rd_idx_ff   <= idx_ff[ADDR_W-1:0];
      prompt_d_ff <= prm_cnt_ff < PRM_K;
      if (state_ff == pspwi_pkg::ST_ACC) begin
         max_ff  <= '1;
         peak_ff <= '0;
      end else if ((state_ff == pspwi_pkg::ST_SCAN) && rdv_ff && (rd_first_ff > max_ff)) begin
         max_ff  <= rd_first_ff;
         peak_ff <= rd_idx_ff;
      end
      if (scan_done) begin
         prm_cnt_ff <= '0;
         tot_b_ff   <= '0;
         pr_b_ff    <= '0;
         tot_f_ff   <= '0;
         pr_f_ff    <= '0;
      end else begin
         if (issue && (prm_cnt_ff < PRM_K)) begin
            prm_cnt_ff <= prm_cnt_ff + 1'b1;
         end
         if ((state_ff == pspwi_pkg::ST_SUM) && rdv_ff) begin
            tot_b_ff <= tot_b_ff + b_ext;
            tot_f_ff <= tot_f_ff + f_ext;
            if (prompt_d_ff) begin
               pr_b_ff <= pr_b_ff + b_ext;
               pr_f_ff <= pr_f_ff + f_ext;
            end
         end
      end
   end

   assign rsp_peak_amplitude = max_ff;
   assign rsp_peak_offset    = peak_ff;
   assign rsp_total_both     = sat_sum(tot_b_ff);
   assign rsp_prompt_both    = sat_sum(pr_b_ff);
   assign rsp_total_first    = sat_sum(tot_f_ff);
   assign rsp_prompt_first   = sat_sum(pr_f_ff);

   assign peak_ok       = (CNT_W'(rsp_peak_offset) < w_eff) || (rsp_peak_offset == '0);
   assign peak_floor_ok = !rsp_peak_amplitude[EW-1] || (rsp_peak_amplitude == '1);
   assign clear_entry   = (state_ff == pspwi_pkg::ST_CLEAR) && (idx_ff == '0);
   assign acc_exit_ok   = (state_ff == pspwi_pkg::ST_IDLE) || (state_ff == pspwi_pkg::ST_SCAN);

   `PSPWI_ASSERT_NEXT(a_done_clears, clock, reset, rsp_valid, clear_entry)
   `PSPWI_ASSERT_NEXT(a_acc_exit, clock, reset, state_ff == pspwi_pkg::ST_ACC, acc_exit_ok)
   `PSPWI_ASSERT_IMP(a_peak_in_window, clock, reset, rsp_valid, peak_ok)
   `PSPWI_ASSERT_IMP(a_peak_floor, clock, reset, rsp_valid, peak_floor_ok)
endmodule
`default_nettype wire
